/* rtl/core/msqla_pkg.sv */
// Shared types, status codes and defaults for the message slot queue.
package msqla_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int SLOT_BYTES_DEF = 16;

    localparam logic [7:0] CR_BYTE = 8'h0d;

    localparam logic [1:0] ST_ECHO  = 2'd0;
    localparam logic [1:0] ST_MSG   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_HALT  = 2'd3;

    localparam logic ACT_RX  = 1'b0;
    localparam logic ACT_POP = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_byte;
        logic       last_of_run;
    } out_word_t;

    typedef struct packed {
        logic       latch;
        logic       line_wr;
        logic       set_halt;
        logic       copy_rd;
        logic       push_done;
        logic       pop_en;
        logic       pop_done;
        logic       res_load;
        logic [1:0] res_code;
    } cmd_t;

    typedef struct packed {
        logic halted;
        logic action;
        logic line_done;
        logic ring_full;
        logic ring_empty;
        logic copy_last;
        logic out_free;
        logic pop_last_move;
    } sts_t;

endpackage

/* rtl/core/message_slot_queue_line_assembly.sv */
// Top level: message slot queue with line assembly.
//
//   port group   dir  payload     meaning
//   s_*          in   in_word_t   received byte or pop request
//   m_*          out  out_word_t  echo, message byte, empty or halted status
//
// An echo, empty or halted result is loaded once the output register is free; the next word
// is taken after that. A completed line is first copied into a slot: the line RAM read port
// copies one byte a cycle. A pop loads the slot's bytes into the output register one byte a
// cycle from the slot RAM read port, slower while m_ready is low.
// One item is in work at a time.
// Reset clears indexes, line valid bits and control; the slot RAM needs no clearing pass.
module message_slot_queue_line_assembly #(
    parameter int SLOT_COUNT = msqla_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = msqla_pkg::SLOT_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  msqla_pkg::in_word_t  s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output msqla_pkg::out_word_t m_word
);

    msqla_pkg::cmd_t cmd;
    msqla_pkg::sts_t sts;

    msqla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    msqla_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new word taken while an item is in work");

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.halted |=> sts.halted)
        else $error("halted flag dropped");

    a_mid_run_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.last_of_run |-> m_word.status == msqla_pkg::ST_MSG)
        else $error("non-final word that is not a message byte");

    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_word.status == msqla_pkg::ST_EMPTY ||
                    m_word.status == msqla_pkg::ST_HALT) |-> m_word.data_byte == 8'd0)
        else $error("status word carries data");
`endif

endmodule

/* rtl/core/msqla_ram.sv */
// Generic single write port, single read port RAM with registered read.
module msqla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/msqla_dp.sv */
// Datapath: line store, slot store, ring indexes, pop staging and output register.
module msqla_dp #(
    parameter int SLOT_COUNT = msqla_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = msqla_pkg::SLOT_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  msqla_pkg::in_word_t s_word,
    input  msqla_pkg::cmd_t     cmd,
    output msqla_pkg::sts_t     sts,
    output logic                m_valid,
    input  logic                m_ready,
    output msqla_pkg::out_word_t m_word
);

    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int LINE_W  = $clog2(SLOT_BYTES);
    localparam int CNT_W   = $clog2(SLOT_BYTES + 1);
    localparam int SADDR_W = $clog2(SLOT_COUNT * SLOT_BYTES);
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(SLOT_BYTES - 1);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(SLOT_COUNT - 1);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        nxt = (idx == IDX_LAST) ? '0 : idx + 1'b1;
        return nxt;
    endfunction

    msqla_pkg::in_word_t  item_reg;
    msqla_pkg::out_word_t out_reg, out_next;
    logic                  halted_reg, halted_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [LINE_W-1:0]     count_reg, count_next;
    logic [SLOT_BYTES-1:0] vld_reg, vld_next;
    logic [LINE_W-1:0]     cpy_idx_reg, cpy_idx_next;
    logic                  cpy_pend_reg;
    logic [LINE_W-1:0]     cpy_widx_reg;
    logic                  cpy_zero_reg;
    logic [CNT_W-1:0]      pop_cnt_reg, pop_cnt_next;
    logic                  hold_v_reg, hold_v_next;
    logic                  hold_last_reg, hold_last_next;
    logic                  m_valid_reg, m_valid_next;

    logic [7:0]         line_rdata;
    logic [7:0]         slot_rdata;
    logic [7:0]         slot_wdata;
    logic [SADDR_W-1:0] tail_base;
    logic [SADDR_W-1:0] head_base;
    logic [SADDR_W-1:0] slot_waddr;
    logic [SADDR_W-1:0] slot_raddr;
    logic               line_done;
    logic               out_free;
    logic               move;
    logic               pop_re;

    assign tail_base  = SADDR_W'(tail_reg) * SADDR_W'(SLOT_BYTES);
    assign head_base  = SADDR_W'(head_reg) * SADDR_W'(SLOT_BYTES);
    assign slot_waddr = tail_base + SADDR_W'(cpy_widx_reg);
    assign slot_raddr = head_base + SADDR_W'(pop_cnt_reg[LINE_W-1:0]);
    assign slot_wdata = cpy_zero_reg ? 8'd0 : line_rdata;

    assign line_done = (item_reg.rx_byte == msqla_pkg::CR_BYTE) || (count_reg == LINE_LAST);
    assign out_free  = !m_valid_reg || m_ready;
    assign move      = hold_v_reg && out_free;
    assign pop_re    = cmd.pop_en && (pop_cnt_reg < CNT_W'(SLOT_BYTES)) &&
                       (!hold_v_reg || move);

    msqla_ram #(
        .WIDTH (8),
        .DEPTH (SLOT_BYTES)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (cmd.line_wr),
        .waddr (count_reg),
        .wdata (item_reg.rx_byte),
        .re    (cmd.copy_rd),
        .raddr (cpy_idx_reg),
        .rdata (line_rdata)
    );

    msqla_ram #(
        .WIDTH (8),
        .DEPTH (SLOT_COUNT * SLOT_BYTES)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (cpy_pend_reg),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (pop_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    always_comb begin
        halted_next    = halted_reg | cmd.set_halt;
        head_next      = cmd.pop_done ? ring_next(head_reg) : head_reg;
        tail_next      = cmd.push_done ? ring_next(tail_reg) : tail_reg;
        count_next     = count_reg;
        vld_next       = vld_reg;
        cpy_idx_next   = cpy_idx_reg;
        pop_cnt_next   = pop_cnt_reg;
        hold_v_next    = hold_v_reg;
        hold_last_next = hold_last_reg;
        m_valid_next   = m_valid_reg;
        out_next       = out_reg;

        if (cmd.line_wr) begin
            vld_next[count_reg] = 1'b1;
            if (!line_done) begin
                count_next = count_reg + 1'b1;
            end
        end
        if (cmd.push_done) begin
            count_next = '0;
        end

        if (cmd.latch) begin
            cpy_idx_next = '0;
            pop_cnt_next = '0;
        end else if (cmd.copy_rd) begin
            cpy_idx_next = (cpy_idx_reg == LINE_LAST) ? '0 : cpy_idx_reg + 1'b1;
        end

        if (pop_re) begin
            pop_cnt_next   = pop_cnt_reg + 1'b1;
            hold_v_next    = 1'b1;
            hold_last_next = (pop_cnt_reg[LINE_W-1:0] == LINE_LAST);
        end else if (move) begin
            hold_v_next = 1'b0;
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (move) begin
            m_valid_next         = 1'b1;
            out_next.status      = msqla_pkg::ST_MSG;
            out_next.data_byte   = slot_rdata;
            out_next.last_of_run = hold_last_reg;
        end else if (cmd.res_load) begin
            m_valid_next         = 1'b1;
            out_next.status      = cmd.res_code;
            out_next.data_byte   = (cmd.res_code == msqla_pkg::ST_ECHO) ?
                                   item_reg.rx_byte : 8'd0;
            out_next.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_reg    <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            vld_reg       <= '0;
            cpy_idx_reg   <= '0;
            cpy_pend_reg  <= 1'b0;
            pop_cnt_reg   <= '0;
            hold_v_reg    <= 1'b0;
            hold_last_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            halted_reg    <= halted_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            vld_reg       <= vld_next;
            cpy_idx_reg   <= cpy_idx_next;
            cpy_pend_reg  <= cmd.copy_rd;
            pop_cnt_reg   <= pop_cnt_next;
            hold_v_reg    <= hold_v_next;
            hold_last_reg <= hold_last_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            item_reg <= s_word;
        end
        cpy_widx_reg <= cpy_idx_reg;
        cpy_zero_reg <= !vld_reg[cpy_idx_reg];
        out_reg      <= out_next;
    end

    always_comb begin
        sts.halted        = halted_reg;
        sts.action        = item_reg.action;
        sts.line_done     = line_done;
        sts.ring_full     = (ring_next(tail_reg) == head_reg);
        sts.ring_empty    = (head_reg == tail_reg);
        sts.copy_last     = (cpy_idx_reg == LINE_LAST);
        sts.out_free      = out_free;
        sts.pop_last_move = move && hold_last_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

endmodule

/* rtl/core/msqla_ctrl.sv */
// Controller: sequences receive, line push, pop and single-word results.
module msqla_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  msqla_pkg::sts_t sts,
    output msqla_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECIDE   = 3'd1;
    localparam logic [2:0] S_COPY     = 3'd2;
    localparam logic [2:0] S_COPY_END = 3'd3;
    localparam logic [2:0] S_POP      = 3'd4;
    localparam logic [2:0] S_RESULT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] code_reg, code_next;

    always_comb begin
        state_next   = state_reg;
        code_next    = code_reg;
        cmd          = '0;
        cmd.res_code = code_reg;
        s_ready      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (sts.halted) begin
                    code_next  = msqla_pkg::ST_HALT;
                    state_next = S_RESULT;
                end else if (sts.action == msqla_pkg::ACT_RX) begin
                    cmd.line_wr = 1'b1;
                    if (sts.line_done && sts.ring_full) begin
                        cmd.set_halt = 1'b1;
                        code_next    = msqla_pkg::ST_HALT;
                        state_next   = S_RESULT;
                    end else if (sts.line_done) begin
                        state_next = S_COPY;
                    end else begin
                        code_next  = msqla_pkg::ST_ECHO;
                        state_next = S_RESULT;
                    end
                end else if (sts.ring_empty) begin
                    code_next  = msqla_pkg::ST_EMPTY;
                    state_next = S_RESULT;
                end else begin
                    state_next = S_POP;
                end
            end
            S_COPY: begin
                cmd.copy_rd = 1'b1;
                if (sts.copy_last) begin
                    state_next = S_COPY_END;
                end
            end
            S_COPY_END: begin
                cmd.push_done = 1'b1;
                code_next     = msqla_pkg::ST_ECHO;
                state_next    = S_RESULT;
            end
            S_POP: begin
                cmd.pop_en = 1'b1;
                if (sts.pop_last_move) begin
                    cmd.pop_done = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= msqla_pkg::ST_ECHO;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule
